[sv/alfl_pkg.sv]
// Package for the array-linked list with free list.
// Sizes, operation and status codes, memory write-port types.
// No dependencies.
package alfl_pkg;

	localparam int DEPTH   = 16;
	localparam int SLOT_W  = $clog2(DEPTH);
	localparam int LINK_W  = $clog2(DEPTH + 1);
	localparam int VALUE_W = 31;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 2;
	localparam int OSLOT_W = 4;

	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(DEPTH);

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [LINK_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  addr;
		logic [VALUE_W-1:0] data;
	} val_wr_t;

endpackage

[sv/alfl_link_mem.sv]
// Next-link memory: synchronous read.
// Per-entry valid bits; an entry never written since clear reads as its index + 1.
// Depends on alfl_pkg.
module alfl_link_mem
	import alfl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  link_wr_t          wr,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output logic [LINK_W-1:0] rd_data
);

	logic [LINK_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [LINK_W-1:0] mem_rd_q;
	logic [SLOT_W-1:0] rd_addr_q;
	logic              rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			mem_rd_q  <= mem[rd_addr];
			rd_addr_q <= rd_addr;
			rd_vld_q  <= valid_q[rd_addr];
		end
	end

	// unwritten entry holds the rebuilt chain i+1
	assign rd_data = rd_vld_q ? mem_rd_q : (LINK_W'(rd_addr_q) + LINK_W'(1));

endmodule

[sv/alfl_val_mem.sv]
// Entry value memory: synchronous read, no reset.
// Depends on alfl_pkg.
module alfl_val_mem
	import alfl_pkg::*;
(
	input  logic               clk,
	input  val_wr_t            wr,
	input  logic               rd_en,
	input  logic [SLOT_W-1:0]  rd_addr,
	output logic [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[sv/array_linked_list_free_list_top.sv]
// Array-linked list with free list: top level, control and output register.
// An accepted input transaction moves IDLE to EXEC; EXEC commits into the output
// register, which raises m_tvalid; EXEC holds while the output register is full.
// s_tready is low in EXEC, so a new transaction is accepted only after the link-memory
// read and write-back of the previous one. Reset: list empty (head null), free list 0..DEPTH-1
// via cleared link valid bits, no clearing pass; a clear operation does the same.
// Depends on alfl_pkg, alfl_link_mem, alfl_val_mem.
module array_linked_list_free_list_top
	import alfl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] func, [32:2] value, [39:33] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [1:0] status, [5:2] slot, [36:6] removed_value,
	                               // [37] now_empty, [38] now_full, [39] zero
);

	// two-state sequencer: IDLE accepts and issues reads, EXEC commits
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [FUNC_W-1:0]  func_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [LINK_W-1:0]  head_q;
	logic [LINK_W-1:0]  free_q;

	logic [FUNC_W-1:0]  in_func;
	logic [VALUE_W-1:0] in_value;
	logic               in_acc;
	logic               commit;

	logic [SLOT_W-1:0]  rd_addr;
	logic [LINK_W-1:0]  link_rd;
	logic [VALUE_W-1:0] val_rd;
	link_wr_t           link_wr;
	val_wr_t            val_wr;
	logic               link_clear;

	// next-state and result of the step in EXEC
	logic [LINK_W-1:0]  head_n;
	logic [LINK_W-1:0]  free_n;
	logic [STAT_W-1:0]  status_n;
	logic [SLOT_W-1:0]  slot_n;
	logic [VALUE_W-1:0] removed_n;

	// output register
	logic               out_vld_q;
	logic [STAT_W-1:0]  status_q;
	logic [OSLOT_W-1:0] slot_q;
	logic [VALUE_W-1:0] removed_q;
	logic               empty_q;
	logic               full_q;

	assign in_func  = s_tdata[FUNC_W-1:0];
	assign in_value = s_tdata[FUNC_W+VALUE_W-1:FUNC_W];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	// EXEC holds until the output register is free or drains this cycle
	assign commit   = (state_q == ST_EXEC) && (!out_vld_q || m_tready);

	// remove reads the head slot, anything else reads the first free slot
	assign rd_addr = (in_func == FN_REMOVE) ? head_q[SLOT_W-1:0] : free_q[SLOT_W-1:0];

	alfl_link_mem u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (link_clear),
		.wr      (link_wr),
		.rd_en   (in_acc),
		.rd_addr (rd_addr),
		.rd_data (link_rd)
	);

	alfl_val_mem u_val (
		.clk     (clk),
		.wr      (val_wr),
		.rd_en   (in_acc),
		.rd_addr (rd_addr),
		.rd_data (val_rd)
	);

	always_comb begin
		head_n     = head_q;
		free_n     = free_q;
		status_n   = STAT_DONE;
		slot_n     = '0;
		removed_n  = '0;
		link_wr    = '0;
		val_wr     = '0;
		link_clear = 1'b0;
		priority if (func_s1 == FN_INSERT) begin
			if (free_q == LINK_NULL) begin
				status_n = STAT_FULL;
			end else begin
				// pop free head, link it before the old list head
				slot_n       = free_q[SLOT_W-1:0];
				free_n       = link_rd;
				head_n       = free_q;
				link_wr.en   = commit;
				link_wr.addr = free_q[SLOT_W-1:0];
				link_wr.data = head_q;
				val_wr.en    = commit;
				val_wr.addr  = free_q[SLOT_W-1:0];
				val_wr.data  = value_s1;
			end
		end else if (func_s1 == FN_REMOVE) begin
			if (head_q == LINK_NULL) begin
				status_n = STAT_EMPTY;
			end else begin
				// unlink list head, push it onto the free list
				slot_n       = head_q[SLOT_W-1:0];
				removed_n    = val_rd;
				head_n       = link_rd;
				free_n       = head_q;
				link_wr.en   = commit;
				link_wr.addr = head_q[SLOT_W-1:0];
				link_wr.data = free_q;
			end
		end else if (func_s1 == FN_CLEAR) begin
			head_n     = LINK_NULL;
			free_n     = '0;
			link_clear = commit;
		end else begin
			// unused code: no change
			head_n = head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= LINK_NULL;
			free_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q <= ST_IDLE;
						head_q  <= head_n;
						free_q  <= free_n;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1  <= in_func;
			value_s1 <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q  <= status_n;
			slot_q    <= OSLOT_W'(slot_n);
			removed_q <= removed_n;
			empty_q   <= (head_n == LINK_NULL);
			full_q    <= (free_n == LINK_NULL);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, full_q, empty_q, removed_q, slot_q, status_q};

endmodule
